/* sv/depth_pixel_to_world_point_assert.svh */
// Assertion macros shared by the depth pixel to world point RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DPW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define DPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dpw_pkg.sv */
// Shared types and constants for the depth pixel to world point block.
// No dependencies.
package dpw_pkg;

  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int FRAME_W       = 12;
  localparam int INV_FOCAL_W   = 24;
  localparam int INV_FOCAL_SH  = 25;
  localparam int COEF_W        = 16;
  localparam int COEF_FRAC     = 14;
  localparam int BRIGHT_W      = 8;
  localparam int COLOR_W       = 8;
  localparam int WORLD_W       = 18;

  // Pipeline depth: back-projection stages followed by transform stages.
  localparam int BP_STAGES     = 5;
  localparam int XF_STAGES     = 5;
  localparam int STAGES        = BP_STAGES + XF_STAGES;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_INV_FOCAL        = 3'd2,
    REG_POSE_ROW_X       = 3'd3,
    REG_POSE_ROW_Y       = 3'd4,
    REG_POSE_ROW_Z       = 3'd5,
    REG_TABLE_BRIGHTNESS = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [FRAME_W-1:0]     frame_width;
    logic [FRAME_W-1:0]     frame_height;
    logic [INV_FOCAL_W-1:0] inv_focal;
    logic [CFG_DATA_W-1:0]  pose_row_x;
    logic [CFG_DATA_W-1:0]  pose_row_y;
    logic [CFG_DATA_W-1:0]  pose_row_z;
    logic [BRIGHT_W-1:0]    table_brightness;
  } cfg_t;

  // Per-pixel fields that ride alongside the arithmetic.
  typedef struct packed {
    logic               point_valid;
    logic               is_object;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } side_t;

endpackage

/* sv/dpw_cfg.sv */
// Configuration register file for the depth pixel to world point block.
// Depends on dpw_pkg.
module dpw_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output dpw_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= 12'd640;
      cfg.frame_height     <= 12'd480;
      cfg.inv_focal        <= 24'd27962;
      cfg.pose_row_x       <= 64'h0000_0000_0000_4000;
      cfg.pose_row_y       <= 64'h0000_0000_4000_0000;
      cfg.pose_row_z       <= 64'h0000_4000_0000_0000;
      cfg.table_brightness <= 8'd230;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpw_pkg::REG_FRAME_WIDTH: begin
          cfg.frame_width <= cfg_data[dpw_pkg::FRAME_W-1:0];
        end
        dpw_pkg::REG_FRAME_HEIGHT: begin
          cfg.frame_height <= cfg_data[dpw_pkg::FRAME_W-1:0];
        end
        dpw_pkg::REG_INV_FOCAL: begin
          cfg.inv_focal <= cfg_data[dpw_pkg::INV_FOCAL_W-1:0];
        end
        dpw_pkg::REG_POSE_ROW_X: begin
          cfg.pose_row_x <= cfg_data;
        end
        dpw_pkg::REG_POSE_ROW_Y: begin
          cfg.pose_row_y <= cfg_data;
        end
        dpw_pkg::REG_POSE_ROW_Z: begin
          cfg.pose_row_z <= cfg_data;
        end
        dpw_pkg::REG_TABLE_BRIGHTNESS: begin
          cfg.table_brightness <= cfg_data[dpw_pkg::BRIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/dpw_flow.sv */
// Valid tracking and per-stage load enables for the pixel pipeline.
// Depends on dpw_pkg and depth_pixel_to_world_point_assert.svh.
`include "depth_pixel_to_world_point_assert.svh"

module dpw_flow (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_stall,
  output logic [dpw_pkg::STAGES-1:0] en,
  output logic                       in_stall,
  output logic                       out_valid
);

  localparam int N = dpw_pkg::STAGES;
  localparam logic [N-1:0] ALL_ONES = {N{1'b1}};

  logic [N-1:0] vld;
  logic         accept;
  logic         take;

  // A stage may load when the output drains or a bubble sits at or after it.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      en[k] = !out_stall || ((vld >> k) != (ALL_ONES >> k));
    end
  end

  assign in_stall  = rst || !en[0];
  assign out_valid = vld[N-1];
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  `DPW_ASSERT(a_no_overrun, !(|(vld[N-2:0] & ~en[N-1:1] & en[N-2:0])), "stage overwritten while held")
  `DPW_ASSERT_NEXT(a_fill, accept && !take, $countones(vld) == $past($countones(vld)) + 1, "occupancy did not grow")
  `DPW_ASSERT_NEXT(a_drain, !accept && take, $countones(vld) + 1 == $past($countones(vld)), "occupancy did not shrink")
  `DPW_ASSERT(a_full_stall, !((&vld) && out_stall) || in_stall, "transaction taken while full")

endmodule

/* sv/dpw_backproj.sv */
// Pinhole back-projection pipeline: pixel offsets, depth products, focal scaling.
// Depends on dpw_pkg. Five register stages, loaded by the flow enables.
module dpw_backproj #(
  parameter int  COORD_BITS = 12,
  parameter int  DEPTH_BITS = 16,
  localparam int XC_W       = COORD_BITS + DEPTH_BITS + 2
) (
  input  logic                               clk,
  input  logic [dpw_pkg::BP_STAGES-1:0]      en,
  input  logic [COORD_BITS-1:0]              column,
  input  logic [COORD_BITS-1:0]              row,
  input  logic [DEPTH_BITS-1:0]              depth_mm,
  input  logic [dpw_pkg::FRAME_W-1:0]        frame_width,
  input  logic [dpw_pkg::FRAME_W-1:0]        frame_height,
  input  logic [dpw_pkg::INV_FOCAL_W-1:0]    inv_focal,
  output logic signed [XC_W-1:0]             xc,
  output logic signed [XC_W-1:0]             yc,
  output logic [DEPTH_BITS-1:0]              zc
);

  localparam int OFF_W = COORD_BITS + 2;
  localparam int MAG_W = COORD_BITS + 1;
  localparam int A_W   = DEPTH_BITS + MAG_W;
  localparam int SPLIT = (A_W + 1) / 2;
  localparam int AH_W  = A_W - SPLIT;
  localparam int P_W   = AH_W + dpw_pkg::INV_FOCAL_W;
  localparam int Q_W   = SPLIT + dpw_pkg::INV_FOCAL_W;
  localparam int T_W   = A_W + dpw_pkg::INV_FOCAL_W + 1;
  localparam logic [T_W-1:0] HALF = T_W'(1) << (dpw_pkg::INV_FOCAL_SH - 1);

  // Lane 0 is horizontal, lane 1 vertical.
  logic [COORD_BITS-1:0]   coord [2];
  logic [COORD_BITS-1:0]   size_m [2];
  logic signed [OFF_W-1:0] off [2];
  logic [A_W-1:0]          prod_a [2];
  logic [P_W-1:0]          prod_p [2];
  logic [Q_W-1:0]          prod_q [2];
  logic [T_W-1:0]          total [2];

  logic [MAG_W-1:0]        mag0 [2];
  logic                    neg0 [2];
  logic [DEPTH_BITS-1:0]   d0;
  logic [A_W-1:0]          a1 [2];
  logic                    neg1 [2];
  logic [DEPTH_BITS-1:0]   d1;
  logic [P_W-1:0]          p2 [2];
  logic [Q_W-1:0]          q2 [2];
  logic                    neg2 [2];
  logic [DEPTH_BITS-1:0]   d2;
  logic [A_W-1:0]          res3 [2];
  logic                    neg3 [2];
  logic [DEPTH_BITS-1:0]   d3;

  assign coord[0]  = column;
  assign coord[1]  = row;
  assign size_m[0] = COORD_BITS'(frame_width);
  assign size_m[1] = COORD_BITS'(frame_height);

  // Offset from the image middle in half pixels: 2u + 1 - W.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      off[i]    = $signed({1'b0, coord[i], 1'b1}) - $signed({2'b00, size_m[i]});
      prod_a[i] = d0 * mag0[i];
      prod_p[i] = a1[i][A_W-1:SPLIT] * inv_focal;
      prod_q[i] = a1[i][SPLIT-1:0] * inv_focal;
      total[i]  = T_W'({p2[i], {SPLIT{1'b0}}}) + T_W'(q2[i]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0 <= depth_mm;
      for (int i = 0; i < 2; i++) begin
        neg0[i] <= off[i][OFF_W-1];
        mag0[i] <= off[i][OFF_W-1] ? MAG_W'(-off[i]) : MAG_W'(off[i]);
      end
    end
    if (en[1]) begin
      d1 <= d0;
      for (int i = 0; i < 2; i++) begin
        a1[i]   <= prod_a[i];
        neg1[i] <= neg0[i];
      end
    end
    if (en[2]) begin
      d2 <= d1;
      for (int i = 0; i < 2; i++) begin
        p2[i]   <= prod_p[i];
        q2[i]   <= prod_q[i];
        neg2[i] <= neg1[i];
      end
    end
    if (en[3]) begin
      d3 <= d2;
      for (int i = 0; i < 2; i++) begin
        res3[i] <= total[i][T_W-1:dpw_pkg::INV_FOCAL_SH];
        neg3[i] <= neg2[i];
      end
    end
    if (en[4]) begin
      zc <= d3;
      xc <= neg3[0] ? -$signed({1'b0, res3[0]}) : $signed({1'b0, res3[0]});
      yc <= neg3[1] ? -$signed({1'b0, res3[1]}) : $signed({1'b0, res3[1]});
    end
  end

endmodule

/* sv/dpw_xform.sv */
// One output row of the rigid transform: dot product, rounding, offset, clamp.
// Depends on dpw_pkg. Five register stages, the last being the output register.
module dpw_xform #(
  parameter int  COORD_BITS = 12,
  parameter int  DEPTH_BITS = 16,
  localparam int XC_W       = COORD_BITS + DEPTH_BITS + 2
) (
  input  logic                                clk,
  input  logic [dpw_pkg::XF_STAGES-1:0]       en,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]      pose,
  input  logic signed [XC_W-1:0]              xc,
  input  logic signed [XC_W-1:0]              yc,
  input  logic [DEPTH_BITS-1:0]               zc,
  input  logic                                keep,
  output logic signed [dpw_pkg::WORLD_W-1:0]  world
);

  localparam int CW    = dpw_pkg::COEF_W;
  localparam int L     = XC_W / 2;
  localparam int XH_W  = XC_W - L;
  localparam int PL_W  = CW + L + 1;
  localparam int PH_W  = CW + XH_W;
  localparam int PZ_W  = CW + DEPTH_BITS + 1;
  localparam int LO_W  = ((PL_W > PZ_W) ? PL_W : PZ_W) + 2;
  localparam int HI_W  = PH_W + 1;
  localparam int ACC_W = XC_W + 18;
  localparam int W0_W  = ACC_W - dpw_pkg::COEF_FRAC;
  localparam int W1_W  = W0_W + 1;
  localparam logic signed [ACC_W-1:0] HALF_UP = ACC_W'(1) << (dpw_pkg::COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_DN = HALF_UP - ACC_W'(1);
  localparam logic signed [W1_W-1:0]  LIM_HI  = W1_W'((1 << (dpw_pkg::WORLD_W - 1)) - 1);
  localparam logic signed [W1_W-1:0]  LIM_LO  = W1_W'(-(1 << (dpw_pkg::WORLD_W - 1)));

  logic signed [CW-1:0]    r0, r1, r2, t;
  logic signed [PL_W-1:0]  mxl, myl;
  logic signed [PH_W-1:0]  mxh, myh;
  logic signed [PZ_W-1:0]  mz;
  logic signed [ACC_W-1:0] rsum;
  logic signed [W1_W-1:0]  wt;

  logic signed [PL_W-1:0]  pxl, pyl;
  logic signed [PH_W-1:0]  pxh, pyh;
  logic signed [PZ_W-1:0]  pz;
  logic signed [LO_W-1:0]  lo;
  logic signed [HI_W-1:0]  hi;
  logic signed [ACC_W-1:0] acc;
  logic signed [W0_W-1:0]  w0;

  assign r0 = $signed(pose[CW-1:0]);
  assign r1 = $signed(pose[2*CW-1:CW]);
  assign r2 = $signed(pose[3*CW-1:2*CW]);
  assign t  = $signed(pose[4*CW-1:3*CW]);

  // The camera x and y are split in halves to keep each product narrow.
  assign mxl = r0 * $signed({1'b0, xc[L-1:0]});
  assign mxh = r0 * $signed(xc[XC_W-1:L]);
  assign myl = r1 * $signed({1'b0, yc[L-1:0]});
  assign myh = r1 * $signed(yc[XC_W-1:L]);
  assign mz  = r2 * $signed({1'b0, zc});

  // Round half away from zero before dropping the fraction bits.
  assign rsum = acc + (acc[ACC_W-1] ? HALF_DN : HALF_UP);
  assign wt   = W1_W'(w0) + W1_W'(t);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxl <= mxl;
      pxh <= mxh;
      pyl <= myl;
      pyh <= myh;
      pz  <= mz;
    end
    if (en[1]) begin
      lo <= LO_W'(pxl) + LO_W'(pyl) + LO_W'(pz);
      hi <= HI_W'(pxh) + HI_W'(pyh);
    end
    if (en[2]) begin
      acc <= (ACC_W'(hi) <<< L) + ACC_W'(lo);
    end
    if (en[3]) begin
      w0 <= rsum[ACC_W-1:dpw_pkg::COEF_FRAC];
    end
    if (en[4]) begin
      if (!keep) begin
        world <= '0;
      end else if (wt > LIM_HI) begin
        world <= LIM_HI[dpw_pkg::WORLD_W-1:0];
      end else if (wt < LIM_LO) begin
        world <= LIM_LO[dpw_pkg::WORLD_W-1:0];
      end else begin
        world <= wt[dpw_pkg::WORLD_W-1:0];
      end
    end
  end

endmodule

/* sv/depth_pixel_to_world_point.sv */
// Top level of the depth pixel to world point block.
// Depends on dpw_pkg, dpw_cfg, dpw_flow, dpw_backproj and dpw_xform.

// Converts one RGB-D pixel per clock into a world point. Each pixel transaction
// carries its column, row, depth in millimetres and colour; a depth of zero
// gives a result with point_valid low and every other field zero. Otherwise
// the pixel is back-projected through a pinhole model centred on the image
// middle using the reciprocal focal length, then rotated and translated by
// the configured pose rows, rounded to the nearest millimetre (ties away from
// zero) and clamped to the 18-bit signed range. The colour is passed through,
// and is_object is low when the mean of the three channels reaches the
// table brightness threshold. The pipeline is ten register stages deep, and
// one pixel is accepted every clock while nothing stalls. Throughput is
// limited only by out_stall: each stage loads whenever it is empty or the
// stage after it moves, so bubbles collapse and a held result does not block
// pixels behind it while space remains.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only change while no transaction is in flight.
module depth_pixel_to_world_point #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Pixel input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               column,
  input  logic [COORD_BITS-1:0]               row,
  input  logic [DEPTH_BITS-1:0]               depth_mm,
  input  logic [dpw_pkg::COLOR_W-1:0]         red_in,
  input  logic [dpw_pkg::COLOR_W-1:0]         green_in,
  input  logic [dpw_pkg::COLOR_W-1:0]         blue_in,
  // Point output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                point_valid,
  output logic signed [dpw_pkg::WORLD_W-1:0]  world_x,
  output logic signed [dpw_pkg::WORLD_W-1:0]  world_y,
  output logic signed [dpw_pkg::WORLD_W-1:0]  world_z,
  output logic [dpw_pkg::COLOR_W-1:0]         red_out,
  output logic [dpw_pkg::COLOR_W-1:0]         green_out,
  output logic [dpw_pkg::COLOR_W-1:0]         blue_out,
  output logic                                is_object,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [dpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int N    = dpw_pkg::STAGES;
  localparam int BP   = dpw_pkg::BP_STAGES;
  localparam int XC_W = COORD_BITS + DEPTH_BITS + 2;
  localparam int SUM_W = dpw_pkg::COLOR_W + 2;

  dpw_pkg::cfg_t          cfg;
  logic [N-1:0]           en;
  dpw_pkg::side_t         side_in;
  dpw_pkg::side_t         side [N];
  logic [SUM_W-1:0]       color_sum;
  logic [SUM_W-1:0]       table_level;
  logic signed [XC_W-1:0] xc;
  logic signed [XC_W-1:0] yc;
  logic [DEPTH_BITS-1:0]  zc;

  dpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpw_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .en        (en),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // The mean test is done without division: sum of channels against three
  // times the threshold.
  assign color_sum   = SUM_W'(red_in) + SUM_W'(green_in) + SUM_W'(blue_in);
  assign table_level = SUM_W'({cfg.table_brightness, 1'b0}) + SUM_W'(cfg.table_brightness);

  // Pixels without a depth measurement report all-zero fields.
  always_comb begin
    side_in.point_valid = |depth_mm;
    side_in.is_object   = (|depth_mm) && (color_sum < table_level);
    side_in.red         = (|depth_mm) ? red_in   : '0;
    side_in.green       = (|depth_mm) ? green_in : '0;
    side_in.blue        = (|depth_mm) ? blue_in  : '0;
  end

  // Colour and flags travel stage by stage alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_in;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  dpw_backproj #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_backproj (
    .clk          (clk),
    .en           (en[BP-1:0]),
    .column       (column),
    .row          (row),
    .depth_mm     (depth_mm),
    .frame_width  (cfg.frame_width),
    .frame_height (cfg.frame_height),
    .inv_focal    (cfg.inv_focal),
    .xc           (xc),
    .yc           (yc),
    .zc           (zc)
  );

  dpw_xform #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_xform_x (
    .clk   (clk),
    .en    (en[N-1:BP]),
    .pose  (cfg.pose_row_x),
    .xc    (xc),
    .yc    (yc),
    .zc    (zc),
    .keep  (side[N-2].point_valid),
    .world (world_x)
  );

  dpw_xform #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_xform_y (
    .clk   (clk),
    .en    (en[N-1:BP]),
    .pose  (cfg.pose_row_y),
    .xc    (xc),
    .yc    (yc),
    .zc    (zc),
    .keep  (side[N-2].point_valid),
    .world (world_y)
  );

  dpw_xform #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_xform_z (
    .clk   (clk),
    .en    (en[N-1:BP]),
    .pose  (cfg.pose_row_z),
    .xc    (xc),
    .yc    (yc),
    .zc    (zc),
    .keep  (side[N-2].point_valid),
    .world (world_z)
  );

  assign point_valid = side[N-1].point_valid;
  assign is_object   = side[N-1].is_object;
  assign red_out     = side[N-1].red;
  assign green_out   = side[N-1].green;
  assign blue_out    = side[N-1].blue;

endmodule
